// ===== hdl/hded_pkg.sv =====
// Shared types and constants for the HyStart delay-increase exit detector.
package hded_pkg;

  // Field widths of the event and result items.
  localparam int unsigned PN_W     = 62;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned OP_W     = 2;

  // Configuration port geometry.
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;

  // Register indexes, taken from byte address bits [4:2].
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SHIFT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WINDOW  = 3'd4;

  // Register values after reset.
  localparam logic [CNT_W-1:0]   MIN_SAMPLES_RST = 8'd8;
  localparam logic [TIME_W-1:0]  DELAY_MIN_RST   = 32'd4000;
  localparam logic [TIME_W-1:0]  DELAY_MAX_RST   = 32'd16000;
  localparam logic [SHIFT_W-1:0] DELAY_SHIFT_RST = 5'd3;
  localparam logic [TIME_W-1:0]  LOW_WINDOW_RST  = 32'd23360;

  // Saturation value of the per-round sample counter.
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Event kinds.
  typedef enum logic [OP_W-1:0] {
    OP_SENT    = 2'd0,
    OP_ACKED   = 2'd1,
    OP_RTT     = 2'd2,
    OP_RESTART = 2'd3
  } opcode_e;

endpackage

// ===== hdl/hystart_delay_exit_detector_unit.sv =====
// Top level of the HyStart delay-increase exit detector with its APB register file.
// A result is offered from the result register, which takes each event from the input register.
// Throughput: one event per cycle while results are taken; an input register and a result register part the channels.
// The threshold add and window compare happen in the input stage, the round update in the next.
// Reset (rst_ni low, asynchronous) empties both stages, clears the round state and loads
// the register defaults.
module hystart_delay_exit_detector_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Event channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [hded_pkg::OP_W-1:0]          opcode_i,
  input  logic [hded_pkg::PN_W-1:0]          packet_number_i,
  input  logic [hded_pkg::TIME_W-1:0]        latest_rtt_us_i,
  input  logic [hded_pkg::TIME_W-1:0]        flow_min_rtt_us_i,
  input  logic [hded_pkg::TIME_W-1:0]        cwnd_bytes_i,
  // Result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               exit_slow_start_o,
  output logic                               round_open_o,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hded_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [hded_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [hded_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import hded_pkg::*;

  // Configuration registers.
  logic [CNT_W-1:0]   min_samples_q;
  logic [TIME_W-1:0]  delay_min_q;
  logic [TIME_W-1:0]  delay_max_q;
  logic [SHIFT_W-1:0] delay_shift_q;
  logic [TIME_W-1:0]  low_window_q;

  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = paddr[CFG_ADDR_W-1:2];

  // Register writes complete in the APB access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q <= MIN_SAMPLES_RST;
      delay_min_q   <= DELAY_MIN_RST;
      delay_max_q   <= DELAY_MAX_RST;
      delay_shift_q <= DELAY_SHIFT_RST;
      low_window_q  <= LOW_WINDOW_RST;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_MIN_SAMPLES: min_samples_q <= pwdata[CNT_W-1:0];
        REG_DELAY_MIN:   delay_min_q   <= pwdata[TIME_W-1:0];
        REG_DELAY_MAX:   delay_max_q   <= pwdata[TIME_W-1:0];
        REG_DELAY_SHIFT: delay_shift_q <= pwdata[SHIFT_W-1:0];
        REG_LOW_WINDOW:  low_window_q  <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back; unused addresses read as zero.
  always_comb begin
    case (cfg_idx)
      REG_MIN_SAMPLES: prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, min_samples_q};
      REG_DELAY_MIN:   prdata = delay_min_q;
      REG_DELAY_MAX:   prdata = delay_max_q;
      REG_DELAY_SHIFT: prdata = {{(CFG_DATA_W-SHIFT_W){1'b0}}, delay_shift_q};
      REG_LOW_WINDOW:  prdata = low_window_q;
      default:         prdata = '0;
    endcase
  end

  // Pipeline handshake: the input stage moves on whenever the result register is free or being emptied.
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_xfer;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;
  assign in_xfer    = in_valid_i & in_ready_o;

  // Threshold for the flow minimum: shifted, clamped above, then clamped below.
  logic [TIME_W-1:0] thr_shifted;
  logic [TIME_W-1:0] thr_upper;
  logic [TIME_W-1:0] thr_final;
  logic [TIME_W:0]   thr_sum_d;

  always_comb begin
    thr_shifted = flow_min_rtt_us_i >> delay_shift_q;
    thr_upper   = (thr_shifted > delay_max_q) ? delay_max_q : thr_shifted;
    thr_final   = (thr_upper < delay_min_q) ? delay_min_q : thr_upper;
    thr_sum_d   = {1'b0, flow_min_rtt_us_i} + {1'b0, thr_final};
  end

  // Input stage payload.
  opcode_e           op_q;
  logic [PN_W-1:0]   pn_q;
  logic [TIME_W-1:0] rtt_q;
  logic [TIME_W:0]   thr_sum_q;
  logic              cwnd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q      <= opcode_e'(opcode_i);
      pn_q      <= packet_number_i;
      rtt_q     <= latest_rtt_us_i;
      thr_sum_q <= thr_sum_d;
      cwnd_ok_q <= (cwnd_bytes_i >= low_window_q);
    end
  end

  // Round state.
  logic [PN_W-1:0]   round_end_q, round_end_d;
  logic [PN_W-1:0]   last_sent_q, last_sent_d;
  logic [TIME_W-1:0] round_min_q, round_min_d;
  logic [CNT_W-1:0]  sample_cnt_q, sample_cnt_d;
  logic              round_started_q, round_started_d;
  logic              rise_found_q, rise_found_d;
  logic              exit_d;

  // Next round state and decision for the event in the input stage.
  always_comb begin
    round_end_d     = round_end_q;
    last_sent_d     = last_sent_q;
    round_min_d     = round_min_q;
    sample_cnt_d    = sample_cnt_q;
    round_started_d = round_started_q;
    rise_found_d    = rise_found_q;
    exit_d          = 1'b0;
    case (op_q)
      OP_SENT: begin
        last_sent_d = pn_q;
      end
      OP_ACKED: begin
        if (round_end_q < pn_q) round_started_d = 1'b0;
      end
      OP_RTT: begin
        // A sample with no open round starts a new one at the last sent packet.
        if (!round_started_q) begin
          round_end_d     = last_sent_q;
          round_min_d     = '0;
          sample_cnt_d    = '0;
          round_started_d = 1'b1;
        end
        if (rise_found_q) begin
          exit_d = 1'b1;
        end else begin
          if (sample_cnt_d != CNT_MAX) sample_cnt_d = sample_cnt_d + 1'b1;
          if ((sample_cnt_d <= min_samples_q) &&
              ((round_min_d == '0) || (round_min_d > rtt_q))) begin
            round_min_d = rtt_q;
          end
          if ((sample_cnt_d == min_samples_q) && ({1'b0, round_min_d} > thr_sum_q)) begin
            rise_found_d = 1'b1;
          end
          exit_d = rise_found_d & cwnd_ok_q;
        end
      end
      OP_RESTART: begin
        round_started_d = 1'b0;
        rise_found_d    = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_end_q     <= '0;
      last_sent_q     <= '0;
      round_min_q     <= '0;
      sample_cnt_q    <= '0;
      round_started_q <= 1'b0;
      rise_found_q    <= 1'b0;
    end else if (advance) begin
      round_end_q     <= round_end_d;
      last_sent_q     <= last_sent_d;
      round_min_q     <= round_min_d;
      sample_cnt_q    <= sample_cnt_d;
      round_started_q <= round_started_d;
      rise_found_q    <= rise_found_d;
    end
  end

  // Result register.
  logic exit_q;
  logic round_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      exit_q       <= exit_d;
      round_open_q <= round_started_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign exit_slow_start_o = exit_q;
  assign round_open_o      = round_open_q;

endmodule

// ===== hdl/hded_checker.sv =====
// Port-level checker for the HyStart delay-increase exit detector and its bind.
module hded_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic exit_slow_start_o,
  input logic round_open_o
);

  // A result that is offered stays, unchanged, until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(exit_slow_start_o) && $stable(round_open_o)))
    else $error("result changed or dropped before its transfer");

  // An empty result register never blocks the event channel.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("event channel stalled with an empty result register");

  // A consumer that takes results never stalls the event channel.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("event channel stalled while results are taken");

  // An event taken with the output empty reaches the output through the input register and the result register.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |-> ##2 out_valid_o)
    else $error("result missing two cycles after event transfer");

endmodule

bind hystart_delay_exit_detector_unit hded_checker u_hded_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .exit_slow_start_o (exit_slow_start_o),
  .round_open_o      (round_open_o)
);

// ===== tb/sv/hystart_exit_checker.sv =====
// Checker for the HyStart delay-increase exit detector: predicts each result and compares it.
module hystart_exit_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_o,
  input  logic [hded_pkg::OP_W-1:0]       opcode_i,
  input  logic [hded_pkg::PN_W-1:0]       packet_number_i,
  input  logic [hded_pkg::TIME_W-1:0]     latest_rtt_us_i,
  input  logic [hded_pkg::TIME_W-1:0]     flow_min_rtt_us_i,
  input  logic [hded_pkg::TIME_W-1:0]     cwnd_bytes_i,
  input  logic                            out_valid_o,
  input  logic                            out_ready_i,
  input  logic                            exit_slow_start_o,
  input  logic                            round_open_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hded_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hded_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                            pready,
  output int                              errors_o,
  output int                              outstanding_o,
  output int                              results_o,
  output int                              exits_o
);
  import hded_pkg::*;

  typedef struct packed {
    logic exit_slow_start;
    logic round_open;
  } verdict_t;

  // Verdicts predicted for accepted events, oldest first.
  verdict_t verdicts_q[$];

  // Copy of the register file, kept up to date from the write transfers on the APB port.
  logic [CNT_W-1:0]   min_samples_cfg;
  logic [TIME_W-1:0]  delay_min_cfg;
  logic [TIME_W-1:0]  delay_max_cfg;
  logic [SHIFT_W-1:0] delay_shift_cfg;
  logic [TIME_W-1:0]  low_window_cfg;

  // Copy of the round state.
  logic [PN_W-1:0]   round_end_pn;
  logic [PN_W-1:0]   last_sent_pn;
  logic [TIME_W-1:0] round_min_rtt;
  logic [CNT_W-1:0]  sample_cnt;
  logic              round_active;
  logic              rise_seen;

  // Advances the round state by one event and returns the verdict that it produces.
  function automatic verdict_t hystart_verdict(input opcode_e op, input logic [PN_W-1:0] pn,
                                               input logic [TIME_W-1:0] rtt,
                                               input logic [TIME_W-1:0] flow_min,
                                               input logic [TIME_W-1:0] cwnd);
    logic [TIME_W-1:0] thr;
    verdict_t v;
    v = '0;
    case (op)
      OP_SENT: begin
        last_sent_pn = pn;
      end
      OP_ACKED: begin
        if (pn > round_end_pn) round_active = 1'b0;
      end
      OP_RTT: begin
        // The first sample after a closed round opens a new one at the last sent packet.
        if (!round_active) begin
          round_end_pn  = last_sent_pn;
          round_min_rtt = '0;
          sample_cnt    = '0;
          round_active  = 1'b1;
        end
        if (rise_seen) begin
          v.exit_slow_start = 1'b1;
        end else begin
          if (sample_cnt != CNT_MAX) sample_cnt = sample_cnt + 1'b1;
          if (sample_cnt <= min_samples_cfg && (round_min_rtt == '0 || round_min_rtt > rtt))
            round_min_rtt = rtt;
          // The threshold is clamped with the lower bound winning when the bounds cross.
          if (sample_cnt == min_samples_cfg) begin
            thr = flow_min >> delay_shift_cfg;
            if (thr > delay_max_cfg) thr = delay_max_cfg;
            if (thr < delay_min_cfg) thr = delay_min_cfg;
            if ({2'b00, round_min_rtt} > {2'b00, flow_min} + {2'b00, thr}) rise_seen = 1'b1;
          end
          v.exit_slow_start = rise_seen && (cwnd >= low_window_cfg);
        end
      end
      OP_RESTART: begin
        round_active = 1'b0;
        rise_seen    = 1'b0;
      end
      default: ;
    endcase
    v.round_open = round_active;
    return v;
  endfunction

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      min_samples_cfg = MIN_SAMPLES_RST;
      delay_min_cfg   = DELAY_MIN_RST;
      delay_max_cfg   = DELAY_MAX_RST;
      delay_shift_cfg = DELAY_SHIFT_RST;
      low_window_cfg  = LOW_WINDOW_RST;
      round_end_pn    = '0;
      last_sent_pn    = '0;
      round_min_rtt   = '0;
      sample_cnt      = '0;
      round_active    = 1'b0;
      rise_seen       = 1'b0;
      verdicts_q.delete();
      errors_o        = 0;
      outstanding_o   = 0;
      results_o       = 0;
      exits_o         = 0;
    end else begin
      // Register writes; indexes outside the register file are ignored.
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_IDX_W+1:2])
          REG_MIN_SAMPLES: min_samples_cfg = pwdata[CNT_W-1:0];
          REG_DELAY_MIN:   delay_min_cfg   = pwdata[TIME_W-1:0];
          REG_DELAY_MAX:   delay_max_cfg   = pwdata[TIME_W-1:0];
          REG_DELAY_SHIFT: delay_shift_cfg = pwdata[SHIFT_W-1:0];
          REG_LOW_WINDOW:  low_window_cfg  = pwdata[TIME_W-1:0];
          default: ;
        endcase
      end

      // An event transfer queues its predicted verdict.
      if (in_valid_i && in_ready_o)
        verdicts_q.push_back(hystart_verdict(opcode_e'(opcode_i), packet_number_i,
                                             latest_rtt_us_i, flow_min_rtt_us_i, cwnd_bytes_i));

      // A result transfer is compared with the oldest verdict.
      if (out_valid_o && out_ready_i) begin
        results_o = results_o + 1;
        if (exit_slow_start_o === 1'b1) exits_o = exits_o + 1;
        if (verdicts_q.size() == 0) begin
          $error("result with no event pending: exit_slow_start=%b round_open=%b",
                 exit_slow_start_o, round_open_o);
          errors_o = errors_o + 1;
        end else begin
          want = verdicts_q.pop_front();
          if (exit_slow_start_o !== want.exit_slow_start) begin
            $error("exit_slow_start: expected %b, got %b", want.exit_slow_start,
                   exit_slow_start_o);
            errors_o = errors_o + 1;
          end
          if (round_open_o !== want.round_open) begin
            $error("round_open: expected %b, got %b", want.round_open, round_open_o);
            errors_o = errors_o + 1;
          end
        end
      end
      outstanding_o = verdicts_q.size();
    end
  end

endmodule

// ===== tb/sv/hystart_delay_exit_detector_unit_tb.sv =====
// Testbench top for the HyStart delay-increase exit detector: stimulus, settings and verdict.
module hystart_delay_exit_detector_unit_tb;
  import hded_pkg::*;

  // Index past the end of the register file, used to show that such writes are ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;
  localparam int unsigned NUM_SETTINGS = 8;
  localparam int unsigned SATURATION_SETTING = 4;
  localparam int unsigned EVENTS_PER_SETTING = 52;

  logic                  clk_i             = 1'b0;
  logic                  rst_ni            = 1'b0;
  logic                  in_valid_i        = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       opcode_i          = OP_SENT;
  logic [PN_W-1:0]       packet_number_i   = '0;
  logic [TIME_W-1:0]     latest_rtt_us_i   = '0;
  logic [TIME_W-1:0]     flow_min_rtt_us_i = '0;
  logic [TIME_W-1:0]     cwnd_bytes_i      = '0;
  logic                  out_valid_o;
  logic                  out_ready_i       = 1'b0;
  logic                  exit_slow_start_o;
  logic                  round_open_o;
  logic                  psel              = 1'b0;
  logic                  penable           = 1'b0;
  logic                  pwrite            = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr             = '0;
  logic [CFG_DATA_W-1:0] pwdata            = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int outstanding;
  int results_seen;
  int exits_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned events_sent   = 0;
  logic [PN_W-1:0] next_pn   = '0;

  // Register values as last written, used only to aim the stimulus.
  logic [CNT_W-1:0]   cur_min_samples = MIN_SAMPLES_RST;
  logic [TIME_W-1:0]  cur_delay_min   = DELAY_MIN_RST;
  logic [TIME_W-1:0]  cur_delay_max   = DELAY_MAX_RST;
  logic [SHIFT_W-1:0] cur_delay_shift = DELAY_SHIFT_RST;
  logic [TIME_W-1:0]  cur_low_window  = LOW_WINDOW_RST;

  hystart_delay_exit_detector_unit u_top (.*);

  hystart_exit_checker u_checker (
    .*,
    .errors_o      (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results_seen),
    .exits_o       (exits_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // The result side stalls at random.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle_pct);

  function automatic logic [PN_W-1:0] random_pn();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[PN_W-1:0];
  endfunction

  // Offers one event after an optional idle gap and returns at the falling edge after its transfer.
  task automatic send_event(input opcode_e op, input logic [PN_W-1:0] pn,
                            input logic [TIME_W-1:0] rtt, input logic [TIME_W-1:0] flow,
                            input logic [TIME_W-1:0] cwnd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i        <= 1'b1;
    opcode_i          <= op;
    packet_number_i   <= pn;
    latest_rtt_us_i   <= rtt;
    flow_min_rtt_us_i <= flow;
    cwnd_bytes_i      <= cwnd;
    do @(posedge clk_i); while (!in_ready_o);
    events_sent++;
    @(negedge clk_i);
  endtask

  // Holds the event side off until every predicted result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // One APB write: setup phase, access phase until pready, then idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Loads one register setting; some writes carry junk in the unused upper bits.
  task automatic apply_setting(input int unsigned idx);
    logic [31:0] v_ms, v_dmin, v_dmax, v_shift, v_low;
    case (idx)
      0: begin v_ms = 32'hFFFF_FF08; v_dmin = 4000; v_dmax = 16000;
               v_shift = 32'hFFFF_FFE3; v_low = 23360; end
      1: begin v_ms = 1; v_dmin = 0; v_dmax = 32'hFFFF_FFFF; v_shift = 0; v_low = 0; end
      2: begin v_ms = 3; v_dmin = 5000; v_dmax = 100; v_shift = 31; v_low = 32'hFFFF_FFFF; end
      3: begin v_ms = 0; v_dmin = 100; v_dmax = 2000; v_shift = 4; v_low = 10000; end
      4: begin v_ms = 255; v_dmin = 4000; v_dmax = 16000; v_shift = 3; v_low = 0; end
      5: begin v_ms = 6; v_dmin = 32'hFFFF_FFFF; v_dmax = 0; v_shift = 1; v_low = 23360; end
      6: begin v_ms = 254; v_dmin = 0; v_dmax = 0; v_shift = 5; v_low = 1; end
      default: begin v_ms = 32'h1234_5602; v_dmin = 1000; v_dmax = 3000;
                     v_shift = 32'h0000_0142; v_low = 23360; end
    endcase
    write_reg(REG_MIN_SAMPLES, v_ms);
    write_reg(REG_DELAY_MIN, v_dmin);
    write_reg(REG_DELAY_MAX, v_dmax);
    write_reg(REG_DELAY_SHIFT, v_shift);
    write_reg(REG_LOW_WINDOW, v_low);
    if (idx == 2 || idx == NUM_SETTINGS - 1) write_reg(REG_UNMAPPED, $urandom);
    cur_min_samples = v_ms[CNT_W-1:0];
    cur_delay_min   = v_dmin;
    cur_delay_max   = v_dmax;
    cur_delay_shift = v_shift[SHIFT_W-1:0];
    cur_low_window  = v_low;
  endtask

  // Picks an RTT near the rise boundary for the given flow minimum.
  function automatic logic [TIME_W-1:0] pick_rtt(input logic [TIME_W-1:0] flow);
    longint unsigned thr, span, r;
    if ($urandom_range(9) == 0) return $urandom;
    thr = 64'(flow >> cur_delay_shift);
    if (thr > 64'(cur_delay_max)) thr = 64'(cur_delay_max);
    if (thr < 64'(cur_delay_min)) thr = 64'(cur_delay_min);
    span = thr + thr / 2 + 64;
    if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
    r = 64'(flow) + 64'($urandom_range(0, span[31:0]));
    if (r > 64'hFFFF_FFFF) r = 64'hFFFF_FFFF;
    return r[TIME_W-1:0];
  endfunction

  // Picks a window just around the low-window register, or anything at all.
  function automatic logic [TIME_W-1:0] pick_cwnd();
    longint signed c;
    if ($urandom_range(1) == 0) return $urandom;
    c = longint'(cur_low_window) + $urandom_range(0, 4) - 2;
    if (c < 0) c = 0;
    if (c > 64'sh0_FFFF_FFFF) c = 64'sh0_FFFF_FFFF;
    return c[TIME_W-1:0];
  endfunction

  // Mostly well-formed rounds with random content, mixed with bursts of random events.
  task automatic run_rounds(input int unsigned count);
    int unsigned stop_at, n;
    logic [TIME_W-1:0] flow;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 4))
          send_event(opcode_e'($urandom_range(3)), random_pn(), $urandom, $urandom, $urandom);
      end else begin
        repeat ($urandom_range(1, 3)) begin
          next_pn = next_pn + PN_W'($urandom_range(1, 4));
          send_event(OP_SENT, next_pn, $urandom, $urandom, $urandom);
        end
        flow = ($urandom_range(9) == 0) ? $urandom : $urandom_range(200, 200000);
        n = $urandom_range(0, (cur_min_samples > 20) ? 22 : cur_min_samples + 2);
        if ($urandom_range(19) == 0) n = cur_min_samples + 2;
        repeat (n) begin
          if ($urandom_range(7) == 0) begin
            next_pn = next_pn + 1'b1;
            send_event(OP_SENT, next_pn, $urandom, $urandom, $urandom);
          end
          if ($urandom_range(9) == 0)
            send_event(OP_ACKED, next_pn - PN_W'($urandom_range(0, 8)), $urandom, $urandom,
                       $urandom);
          send_event(OP_RTT, random_pn(), pick_rtt(flow), flow, pick_cwnd());
        end
        // Close the round by a late ack or a restart, or leave it open.
        case ($urandom_range(2))
          0: send_event(OP_ACKED, next_pn + PN_W'($urandom_range(1, 3)), $urandom, $urandom,
                        $urandom);
          1: send_event(OP_RESTART, random_pn(), $urandom, $urandom, $urandom);
          default: send_event(OP_ACKED, next_pn - PN_W'($urandom_range(0, 2)), $urandom,
                              $urandom, $urandom);
        endcase
      end
    end
  endtask

  // One long round that drives the sample counter into saturation, then rises late.
  task automatic saturate_counter();
    send_event(OP_RESTART, random_pn(), $urandom, $urandom, $urandom);
    next_pn = next_pn + 1'b1;
    send_event(OP_SENT, next_pn, $urandom, $urandom, $urandom);
    repeat (262)
      send_event(OP_RTT, random_pn(), 32'd20000 + $urandom_range(0, 4500), 32'd20000, $urandom);
    repeat (10)
      send_event(OP_RTT, random_pn(), 32'd30000 + $urandom_range(0, 100), 32'd1000, $urandom);
    send_event(OP_RESTART, random_pn(), $urandom, $urandom, $urandom);
  endtask

  // Main sequence.
  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 25;
    recv_idle_pct = 79;

    // Directed events under the reset settings.
    send_event(OP_SENT, {PN_W{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(OP_SENT, '0, '0, '0, '0);
    send_event(OP_RTT, {PN_W{1'b1}}, 32'd0, 32'd0, 32'd0);
    send_event(OP_ACKED, '0, $urandom, $urandom, $urandom);
    send_event(OP_ACKED, {PN_W{1'b1}}, $urandom, $urandom, $urandom);
    send_event(OP_ACKED, random_pn(), $urandom, $urandom, $urandom);
    send_event(OP_RESTART, random_pn(), $urandom, $urandom, $urandom);
    send_event(OP_SENT, 62'd100, $urandom, $urandom, $urandom);
    // Eight samples whose minimum rises past the threshold, the last under a small window.
    send_event(OP_RTT, random_pn(), 32'd30000, 32'd10000, 32'hFFFF_FFFF);
    send_event(OP_RTT, random_pn(), 32'hFFFF_FFFF, 32'd10000, 32'd23360);
    send_event(OP_RTT, random_pn(), 32'd29000, 32'd10000, 32'd0);
    send_event(OP_RTT, random_pn(), 32'd28000, 32'd10000, 32'd0);
    send_event(OP_RTT, random_pn(), 32'd27000, 32'd10000, 32'd0);
    send_event(OP_RTT, random_pn(), 32'd26000, 32'd10000, 32'd0);
    send_event(OP_RTT, random_pn(), 32'd25000, 32'd10000, 32'd0);
    send_event(OP_RTT, random_pn(), 32'd24000, 32'd10000, 32'd23359);
    // With the rise flag set the exit is reported whatever the window.
    send_event(OP_RTT, random_pn(), 32'd0, 32'd0, 32'd0);
    send_event(OP_ACKED, 62'd50, $urandom, $urandom, $urandom);
    send_event(OP_SENT, random_pn(), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(OP_RESTART, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(OP_RTT, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(OP_ACKED, {PN_W{1'b1}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();

    // Random traffic under each register setting, with the idle pattern changing by thirds.
    for (int unsigned s = 0; s < NUM_SETTINGS; s++) begin
      if (s >= 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (s >= 3) begin
        send_idle_pct = 79;
        recv_idle_pct = 25;
      end
      apply_setting(s);
      if (s == SATURATION_SETTING) saturate_counter();
      else run_rounds(EVENTS_PER_SETTING);
      wait_for_results();
    end

    repeat (10) @(negedge clk_i);
    $display("Sent %0d events across %0d register settings; %0d results checked, %0d exits.",
             events_sent, NUM_SETTINGS, results_seen, exits_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #4_000_000;
    $display("Run limit reached with %0d results still pending.", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule
